// File: hdl/rpfs_pkg.sv
// rpfs_pkg: types, codes and helpers shared by the palette fade sequencer.
// Used by the top level and its testbench.
// No dependencies.
package rpfs_pkg;

  localparam int ENTRY_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WAIT_W      = 20;
  localparam int HOLD_FACTOR = 10;

  // Request opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd2;

  // Mode selector codes
  localparam logic [1:0] MODE_ONE    = 2'd0;
  localparam logic [1:0] MODE_FADE   = 2'd1;
  localparam logic [1:0] MODE_CHANGE = 2'd2;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [ENTRY_W-1:0] entry_index;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
  } item_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_req_t;

  function automatic logic [7:0] chan_step(input logic [7:0] cur, input logic [7:0] tgt);
    logic [7:0] res;
    if (cur > tgt) res = cur - 8'd1;
    else if (cur < tgt) res = cur + 8'd1;
    else res = cur;
    return res;
  endfunction

  // One unit per channel toward the target color
  function automatic color_t move_toward(input color_t cur, input color_t tgt);
    color_t res;
    res.red   = chan_step(cur.red, tgt.red);
    res.green = chan_step(cur.green, tgt.green);
    res.blue  = chan_step(cur.blue, tgt.blue);
    return res;
  endfunction

endpackage

// File: hdl/rpfs_chan_if.sv
// rpfs_chan_if: valid/ready channel carrying one payload of type data_t.
// Payload types come from rpfs_pkg.
interface rpfs_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rpfs_ram.sv
// rpfs_ram: generic RAM, one write port, two registered read ports.
// A read of the address written in the same cycle returns the new data.
// No dependencies.
module rpfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= (we && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
    rd_data_b <= (we && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
  end

endmodule

// File: hdl/rgb_palette_fade_sequencer.sv
// rgb_palette_fade_sequencer: one-color, fade and changing-color LED sequencer.
// A result is valid the cycle after its request is taken; one request per cycle, unless
// a configuration write or an untaken result stalls. The palette RAM is read ahead for
// the entries the next tick may need; requests pause while that read is redone after each configuration write.
// Reset (rst, synchronous, active high): palette reads as zero, outputs zero, idle.
// Depends on rpfs_pkg, rpfs_chan_if and rpfs_ram.
module rgb_palette_fade_sequencer #(
  parameter int PALETTE_DEPTH = 8
) (
  input logic        clk,
  input logic        rst,
  rpfs_chan_if.sink   items,
  rpfs_chan_if.source results,
  rpfs_chan_if.sink   cfg
);

  localparam int WRITABLE    = 2 ** rpfs_pkg::ENTRY_W;
  localparam int STORE_DEPTH = (PALETTE_DEPTH < WRITABLE) ? PALETTE_DEPTH : WRITABLE;
  localparam int IDX_W       = $clog2(PALETTE_DEPTH);
  localparam int CNT_W       = $clog2(PALETTE_DEPTH + 1);
  localparam int SA_W        = $clog2(STORE_DEPTH);
  localparam int WAIT_W      = rpfs_pkg::WAIT_W;

  // Configuration
  logic [1:0]  mode_select;
  logic [3:0]  color_count;
  logic [15:0] step_time;

  // Sequencer state
  rpfs_pkg::color_t shown, working, target, pal0, pal1;
  logic [IDX_W-1:0]  seg;
  logic [WAIT_W-1:0] wait_cnt;
  logic              running, fading;
  logic [STORE_DEPTH-1:0] valid;
  logic pf_ok, a_ok, b_ok, out_valid;

  rpfs_pkg::color_t shown_next, working_next, target_next;
  logic [IDX_W-1:0]  seg_next;
  logic [WAIT_W-1:0] wait_next;
  logic              running_next, fading_next;

  logic [CNT_W-1:0] cnt;
  logic             accept, cfg_accept, wr_en;
  logic [SA_W-1:0]  wr_sa;
  rpfs_pkg::color_t wr_color, ram_a, ram_b, pal_a, pal_b;
  logic [IDX_W-1:0] addr_a, addr_b, n1_next;
  logic             a_in, b_in;
  logic [WAIT_W-1:0] hold;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] i,
                                                input logic [CNT_W-1:0] n);
    logic [IDX_W-1:0] r;
    if (i >= (IDX_W+1)'(n)) r = '0;
    else r = i[IDX_W-1:0];
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] n);
    return wrap_idx((IDX_W+1)'(i) + (IDX_W+1)'(1), n);
  endfunction

  // Entries in use: zero counts as one, saturate at the depth
  always_comb begin
    if (color_count == 4'd0) cnt = CNT_W'(1);
    else if (32'(color_count) > PALETTE_DEPTH) cnt = CNT_W'(PALETTE_DEPTH);
    else cnt = CNT_W'(color_count);
  end

  assign cfg.ready     = 1'b1;
  assign cfg_accept    = cfg.valid && cfg.ready;
  assign items.ready   = pf_ok && !cfg.valid && (!out_valid || results.ready);
  assign accept        = items.valid && items.ready;

  assign results.valid           = out_valid;
  assign results.data.red_duty   = shown.red;
  assign results.data.green_duty = shown.green;
  assign results.data.blue_duty  = shown.blue;

  assign wr_color.red   = items.data.red_in;
  assign wr_color.green = items.data.green_in;
  assign wr_color.blue  = items.data.blue_in;
  assign wr_en = accept && items.data.op == rpfs_pkg::OP_WRITE
                 && 32'(items.data.entry_index) < STORE_DEPTH;
  assign wr_sa = items.data.entry_index[SA_W-1:0];

  assign pal_a = a_ok ? ram_a : '0;
  assign pal_b = b_ok ? ram_b : '0;

  assign hold = WAIT_W'({step_time, 3'b000}) + WAIT_W'({step_time, 1'b0});

  always_comb begin
    shown_next   = shown;
    working_next = working;
    target_next  = target;
    seg_next     = seg;
    wait_next    = wait_cnt;
    running_next = running;
    fading_next  = fading;
    if (accept) begin
      unique case (items.data.op)
        rpfs_pkg::OP_TICK: begin
          if (running) begin
            if (wait_cnt <= WAIT_W'(1)) begin
              if (fading) begin
                // pal_a/pal_b hold the entries after seg
                if (working == target) begin
                  seg_next     = next_idx(seg, cnt);
                  working_next = rpfs_pkg::move_toward(pal_a, pal_b);
                  target_next  = pal_b;
                end else begin
                  working_next = rpfs_pkg::move_toward(working, target);
                end
                shown_next = working_next;
                wait_next  = WAIT_W'(step_time);
              end else begin
                shown_next = pal_a;
                seg_next   = next_idx(wrap_idx((IDX_W+1)'(seg), cnt), cnt);
                wait_next  = hold;
              end
            end else begin
              wait_next = wait_cnt - WAIT_W'(1);
            end
          end
        end
        rpfs_pkg::OP_RESTART: begin
          seg_next = '0;
          if (mode_select == rpfs_pkg::MODE_FADE && cnt >= CNT_W'(2)) begin
            running_next = 1'b1;
            fading_next  = 1'b1;
            working_next = rpfs_pkg::move_toward(pal0, pal1);
            target_next  = pal1;
            shown_next   = working_next;
            wait_next    = WAIT_W'(step_time);
          end else if (mode_select == rpfs_pkg::MODE_CHANGE) begin
            running_next = 1'b1;
            fading_next  = 1'b0;
            shown_next   = pal0;
            seg_next     = next_idx('0, cnt);
            wait_next    = hold;
          end else begin
            running_next = 1'b0;
            fading_next  = 1'b0;
            wait_next    = '0;
            shown_next   = pal0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read ahead for the next tick: changing colors needs wrap(seg),
  // a fade segment change needs next(seg) and the entry after it.
  assign n1_next = next_idx(seg_next, cnt);
  assign addr_a  = fading_next ? n1_next : wrap_idx((IDX_W+1)'(seg_next), cnt);
  assign addr_b  = next_idx(n1_next, cnt);
  assign a_in    = 32'(addr_a) < STORE_DEPTH;
  assign b_in    = 32'(addr_b) < STORE_DEPTH;

  rpfs_ram #(
    .WIDTH ($bits(rpfs_pkg::color_t)),
    .DEPTH (STORE_DEPTH)
  ) u_palette (
    .clk       (clk),
    .we        (wr_en),
    .wr_addr   (wr_sa),
    .wr_data   (wr_color),
    .rd_addr_a (addr_a[SA_W-1:0]),
    .rd_data_a (ram_a),
    .rd_addr_b (addr_b[SA_W-1:0]),
    .rd_data_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_select <= rpfs_pkg::MODE_ONE;
      color_count <= 4'd1;
      step_time   <= 16'd10;
      shown       <= '0;
      working     <= '0;
      target      <= '0;
      pal0        <= '0;
      pal1        <= '0;
      seg         <= '0;
      wait_cnt    <= '0;
      running     <= 1'b0;
      fading      <= 1'b0;
      valid       <= '0;
      pf_ok       <= 1'b0;
      a_ok        <= 1'b0;
      b_ok        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_accept) begin
        unique case (cfg.data.index)
          rpfs_pkg::CFG_MODE:  mode_select <= cfg.data.value[1:0];
          rpfs_pkg::CFG_COUNT: color_count <= cfg.data.value[3:0];
          rpfs_pkg::CFG_STEP:  step_time   <= cfg.data.value;
          default: begin
          end
        endcase
      end
      shown    <= shown_next;
      working  <= working_next;
      target   <= target_next;
      seg      <= seg_next;
      wait_cnt <= wait_next;
      running  <= running_next;
      fading   <= fading_next;
      if (wr_en) begin
        valid[wr_sa] <= 1'b1;
        if (items.data.entry_index == rpfs_pkg::ENTRY_W'(0)) pal0 <= wr_color;
        if (items.data.entry_index == rpfs_pkg::ENTRY_W'(1)) pal1 <= wr_color;
      end
      // Entry count may change with a config write; redo the read-ahead
      pf_ok <= !cfg_accept;
      a_ok  <= a_in && (valid[addr_a[SA_W-1:0]] || (wr_en && wr_sa == addr_a[SA_W-1:0]));
      b_ok  <= b_in && (valid[addr_b[SA_W-1:0]] || (wr_en && wr_sa == addr_b[SA_W-1:0]));
      if (accept) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> results.valid)
    else $error("request taken without a result");

  a_no_request_stale_read: assert property (@(posedge clk) disable iff (rst)
    !pf_ok |-> !items.ready)
    else $error("request taken while palette read-ahead is stale");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && items.data.op == rpfs_pkg::OP_TICK && !running) |=> $stable(shown))
    else $error("tick while idle changed the shown color");
`endif

endmodule
